/* design/flsm_pkg.sv */
// Shared types and constants for the first/last substring matcher.
// Used by every module of the block; depends on nothing.

package flsm_pkg;

  localparam int unsigned PAT_MAX  = 32;
  localparam int unsigned TEXT_MAX = 65536;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = $clog2(PAT_MAX + 1);
  localparam int unsigned CNT_W   = $clog2(TEXT_MAX + 1);
  localparam int unsigned SUB_W   = (CNT_W > START_W) ? CNT_W : START_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEXT   = 2'd2
  } req_e;

  // Pattern held newest-first: chars[0] is the last appended character.
  typedef struct packed {
    logic [PAT_MAX-1:0][CHAR_W-1:0] chars;
    logic [PAT_MAX-1:0]             mask;
    logic [LEN_W-1:0]               len;
    logic                           ovf;
    logic                           active;
  } pat_t;

  typedef struct packed {
    logic store;
    logic clear;
  } win_ctl_t;

  typedef struct packed {
    logic               first_found;
    logic [START_W-1:0] first_start;
    logic               last_found;
    logic [START_W-1:0] last_start;
    logic               pattern_too_long;
    logic               text_overflow;
  } res_t;

endpackage

/* design/flsm_pattern.sv */
// Pattern store: newest-first shift register with a thermometer length mask.
// Depends on flsm_pkg.

module flsm_pattern (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      op_valid_i,
  input  flsm_pkg::req_e            req_i,
  input  logic [flsm_pkg::CHAR_W-1:0] char_i,
  output flsm_pkg::pat_t            pat_o
);
  import flsm_pkg::*;

  logic [PAT_MAX-1:0][CHAR_W-1:0] chars_q, chars_d;
  logic [PAT_MAX-1:0]             mask_q, mask_d;
  logic [LEN_W-1:0]               len_q, len_d;
  logic                           ovf_q, ovf_d;
  logic                           full;

  assign full = (len_q == LEN_W'(PAT_MAX));

  always_comb begin
    chars_d = chars_q;
    mask_d  = mask_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    if (op_valid_i) begin
      case (req_i)
        REQ_CLEAR: begin
          mask_d = '0;
          len_d  = '0;
          ovf_d  = 1'b0;
        end
        REQ_APPEND: begin
          if (!full) begin
            // shift older characters one place deeper, new one at the front
            chars_d[0] = char_i;
            mask_d[0]  = 1'b1;
            for (int k = 1; k < PAT_MAX; k++) begin
              chars_d[k] = chars_q[k-1];
              mask_d[k]  = mask_q[k-1];
            end
            len_d = len_q + LEN_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      len_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      mask_q <= mask_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

  always_comb begin
    pat_o.chars  = chars_q;
    pat_o.mask   = mask_q;
    pat_o.len    = len_q;
    pat_o.ovf    = ovf_q;
    pat_o.active = (len_q != '0) && !ovf_q;
  end

endmodule

/* design/flsm_window.sv */
// Text window and parallel compare against the loaded pattern.
// Depends on flsm_pkg; pattern comes from flsm_pattern.

module flsm_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  flsm_pkg::win_ctl_t          ctl_i,
  input  logic [flsm_pkg::CHAR_W-1:0] char_i,
  input  flsm_pkg::pat_t              pat_i,
  output logic                        match_o
);
  import flsm_pkg::*;

  logic [PAT_MAX-1:0][CHAR_W-1:0] win_q, win_nx;
  logic [PAT_MAX-1:0]             wvld_q, wvld_nx, wvld_d;
  logic [PAT_MAX-1:0]             pos_ok;

  // window as it stands once the current character is shifted in
  always_comb begin
    win_nx[0]  = char_i;
    wvld_nx[0] = 1'b1;
    for (int k = 1; k < PAT_MAX; k++) begin
      win_nx[k]  = win_q[k-1];
      wvld_nx[k] = wvld_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < PAT_MAX; k++) begin
      pos_ok[k] = (win_nx[k] == pat_i.chars[k]) || !pat_i.mask[k];
    end
    // every pattern position must face a character that has really arrived
    match_o = pat_i.active && (&pos_ok) && ((pat_i.mask & ~wvld_nx) == '0);
  end

  always_comb begin
    wvld_d = wvld_q;
    if (ctl_i.store) wvld_d = wvld_nx;
    if (ctl_i.clear) wvld_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q <= '0;
    end else begin
      wvld_q <= wvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.store) win_q <= win_nx;
  end

endmodule

/* design/flsm_hits.sv */
// Text counter, overflow flag and first/last hit tracking; builds the result.
// Depends on flsm_pkg.

module flsm_hits (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         op_valid_i,
  input  flsm_pkg::req_e               req_i,
  input  logic                         eot_i,
  input  logic                         match_i,
  input  flsm_pkg::pat_t               pat_i,
  output flsm_pkg::win_ctl_t           ctl_o,
  output flsm_pkg::res_t               res_o
);
  import flsm_pkg::*;

  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
  logic               tovf_q, tovf_d;
  logic               fvld_q, fvld_d, lvld_q, lvld_d;
  logic [START_W-1:0] fstart_q, fstart_d, lstart_q, lstart_d;
  logic [SUB_W-1:0]   diff;
  logic               text, room, store, hit, done;

  assign text    = op_valid_i && (req_i == REQ_TEXT);
  assign room    = (cnt_q < CNT_W'(TEXT_MAX));
  assign store   = text && room;
  assign hit     = store && match_i;
  assign done    = text && eot_i;
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign diff    = SUB_W'(cnt_inc) - SUB_W'(pat_i.len);

  always_comb begin
    cnt_d    = store ? cnt_inc : cnt_q;
    tovf_d   = tovf_q || (text && !room);
    fvld_d   = fvld_q;
    fstart_d = fstart_q;
    lvld_d   = lvld_q;
    lstart_d = lstart_q;
    if (hit) begin
      if (!fvld_q) begin
        fvld_d   = 1'b1;
        fstart_d = diff[START_W-1:0];
      end
      lvld_d   = 1'b1;
      lstart_d = diff[START_W-1:0];
    end
  end

  always_comb begin
    res_o.first_found      = fvld_d;
    res_o.first_start      = fstart_d;
    res_o.last_found       = lvld_d;
    res_o.last_start       = lstart_d;
    res_o.pattern_too_long = pat_i.ovf;
    res_o.text_overflow    = tovf_d;
    ctl_o.store            = store;
    ctl_o.clear            = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      tovf_q   <= 1'b0;
      fvld_q   <= 1'b0;
      fstart_q <= '0;
      lvld_q   <= 1'b0;
      lstart_q <= '0;
    end else if (done) begin
      // text finished: drop all per-text state, keep the pattern
      cnt_q    <= '0;
      tovf_q   <= 1'b0;
      fvld_q   <= 1'b0;
      fstart_q <= '0;
      lvld_q   <= 1'b0;
      lstart_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      tovf_q   <= tovf_d;
      fvld_q   <= fvld_d;
      fstart_q <= fstart_d;
      lvld_q   <= lvld_d;
      lstart_q <= lstart_d;
    end
  end

endmodule

/* design/first_last_substring_matcher_top.sv */
// Top level of the first/last substring matcher.
// Depends on flsm_pkg, flsm_pattern, flsm_window and flsm_hits.
//
// Usage:
//   The input channel carries requests: clear pattern, append a pattern
//   character, or a text character (end_of_text marks the last one). Request
//   code 3 is ignored. Every beat is taken into an input register; while it
//   sits there, the pattern is compared against the text window ending at that
//   character in one parallel pass, and the hit state updates as it leaves.
//   The last text character produces one result beat on the output channel:
//   first/last occurrence starts, pattern-too-long and text-overflow flags.
//   A result is loaded into the output register when its end-of-text beat
//   leaves the input register. Throughput: one beat per cycle while no
//   end-of-text beat is held back.
//   When the receiver stalls, the result holds in the output register; the
//   block keeps taking pattern and ordinary text beats and holds a further
//   end-of-text beat, stalling the input, until the output register frees up.
//   Reset empties the pattern, the text window and all hit state; the block
//   accepts beats as soon as reset is released.

module first_last_substring_matcher_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [flsm_pkg::REQ_W-1:0]    req_type_i,
  input  logic [flsm_pkg::CHAR_W-1:0]   char_value_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          first_found_o,
  output logic [flsm_pkg::START_W-1:0]  first_start_o,
  output logic                          last_found_o,
  output logic [flsm_pkg::START_W-1:0]  last_start_o,
  output logic                          pattern_too_long_o,
  output logic                          text_overflow_o
);
  import flsm_pkg::*;

  logic              s1_valid_q;
  req_e              s1_req_q;
  logic [CHAR_W-1:0] s1_char_q;
  logic              s1_eot_q;
  logic              produces, fire, accept;
  logic              out_valid_q;
  res_t              res_q, res_d;
  pat_t              pat;
  win_ctl_t          win_ctl;
  logic              match;

  assign produces   = (s1_req_q == REQ_TEXT) && s1_eot_q;
  assign fire       = s1_valid_q && (!produces || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q  <= req_e'(req_type_i);
      s1_char_q <= char_value_i;
      s1_eot_q  <= end_of_text_i;
    end
  end

  flsm_pattern u_pattern (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (fire),
    .req_i      (s1_req_q),
    .char_i     (s1_char_q),
    .pat_o      (pat)
  );

  flsm_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (win_ctl),
    .char_i  (s1_char_q),
    .pat_i   (pat),
    .match_o (match)
  );

  flsm_hits u_hits (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (fire),
    .req_i      (s1_req_q),
    .eot_i      (s1_eot_q),
    .match_i    (match),
    .pat_i      (pat),
    .ctl_o      (win_ctl),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && produces) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && produces) res_q <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign first_found_o      = res_q.first_found;
  assign first_start_o      = res_q.first_start;
  assign last_found_o       = res_q.last_found;
  assign last_start_o       = res_q.last_start;
  assign pattern_too_long_o = res_q.pattern_too_long;
  assign text_overflow_o    = res_q.text_overflow;

`ifndef SYNTH
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && produces) |=> out_valid_o)
    else $error("end-of-text beat did not load the output register");

  a_found_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_found_o == last_found_o))
    else $error("first and last search disagree on a hit");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !first_found_o) |-> (first_start_o == '0 && last_start_o == '0))
    else $error("start index nonzero without a hit");

  a_mask_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pat.mask) == int'(pat.len))
    else $error("pattern mask out of step with pattern length");
`endif

endmodule
